// ===== rtl/awvt_pkg.sv =====
// Package for the angle window velocity tracker: widths, reset constants,
// controller command/status structs and the one-hot state encoding.
// No dependencies.
package awvt_pkg;

  localparam int unsigned DepthDefault = 32;
  localparam int unsigned AngleW       = 16;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned VelW         = 26;
  localparam int unsigned FillW        = 6;
  // Dividend |d| * 1000 fits 26 bits
  localparam int unsigned NumW         = 26;
  localparam int unsigned SumW         = 37;
  localparam logic signed [AngleW-1:0] MinReset = 16'sd11520;
  localparam logic signed [AngleW-1:0] MaxReset = 16'sd0;
  localparam logic [9:0] MsPerS = 10'd1000;

  typedef enum logic [9:0] {
    StIdle     = 10'b00_0000_0001,
    StInit     = 10'b00_0000_0010,
    StRdFirst  = 10'b00_0000_0100,
    StCapFirst = 10'b00_0000_1000,
    StCapPair  = 10'b00_0001_0000,
    StStart    = 10'b00_0010_0000,
    StWait     = 10'b00_0100_0000,
    StAvg      = 10'b00_1000_0000,
    StAvgWait  = 10'b01_0000_0000,
    StOut      = 10'b10_0000_0000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;      // latch input item, update ring/min/max
    logic walk_init; // clear accumulators, set walk pointer
    logic rd;        // read at walk pointer, advance pointer
    logic cap_cur;   // capture read data as earlier sample
    logic cap_nxt;   // capture read data as later sample, set up pair
    logic div_start; // start pair divider
    logic acc;       // accumulate pair velocity
    logic avg_start; // start average divider
    logic load_out;  // load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;  // latched item is a clear
    logic walk_any;  // at least two samples
    logic walk_last; // captured pair is the last one
    logic pair_skip; // time step zero
    logic div_done;
    logic any_pairs;
  } sts_t;

endpackage

// ===== rtl/angle_window_velocity_tracker.sv =====
// Angle window velocity tracker, top level: controller, datapath, result register.
// Depends on awvt_pkg, awvt_ctrl, awvt_dp.
//
// Usage:
//  s_axis carries one item per transfer: tdata = {sample time, angle},
//  tuser = action (0 push sample, 1 clear window and min/max).
//  m_axis returns one result per item: peak/avg velocity, lowest/highest
//  angle, fill count; tuser = window_full.
//  One item at a time: the walk reads each stored pair from the sample RAMs
//  and runs a shared serial divider per pair with nonzero time step, plus
//  one more divide for the average; a pair with zero time step skips its
//  divide. A clear or a window under two samples skips the walk. The next
//  item is accepted in the cycle after the result is loaded. Reset empties
//  the window and sets min to 180 degrees, max to 0; no clearing pass is
//  needed. If the receiver stalls, the result waits in the output register
//  and the next item waits before its result is loaded.
module angle_window_velocity_tracker import awvt_pkg::*; #(
  parameter int unsigned Depth = DepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // angle[15:0], sample time[47:16]
  input  logic         s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // peak vel[25:0], avg vel[51:26],
                                      // lowest_angle[67:52], highest_angle[83:68],
                                      // fill_count[89:84], zero[95:90]
  output logic         m_axis_tuser   // window_full
);
  cmd_t cmd;
  sts_t sts;
  logic [VelW-1:0] peak, avg;
  logic signed [AngleW-1:0] lo, hi;
  logic full;
  logic [FillW-1:0] fill;
  logic [95:0] tdata_q;
  logic tuser_q, valid_q;

  awvt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_full_i(valid_q), .out_taken_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd)
  );

  awvt_dp #(.Depth(Depth)) u_dp (
    .clk_i, .rst_ni, .action_i(s_axis_tuser),
    .angle_i(s_axis_tdata[15:0]), .time_i(s_axis_tdata[47:16]),
    .cmd_i(cmd), .sts_o(sts), .peak_o(peak), .avg_o(avg), .min_o(lo),
    .max_o(hi), .full_o(full), .fill_o(fill)
  );

  // Result register: fields packed low to high, zero padded to 96 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (cmd.load_out) valid_q <= 1'b1;
    else if (m_axis_tready) valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      tdata_q <= {6'b00_0000, fill, hi, lo, avg, peak};
      tuser_q <= full;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
endmodule

// ===== rtl/awvt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module awvt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/awvt_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// No dependencies.
module awvt_div #(
  parameter int unsigned NW = 37,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q, quo_d;
  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DW:0]     trial;
  logic [DW+1:0]   diff;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DW-1:0], quo_q[NW-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift one dividend bit into the remainder and try to subtract
      if (!diff[DW+1]) begin
        rem_d = diff[DW:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o  = quo_d;
endmodule

// ===== rtl/awvt_ctrl.sv =====
// Controller state machine of the tracker: sequences the pair walk.
// Depends on awvt_pkg.
module awvt_ctrl import awvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_full_i,
  input  logic out_taken_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = StInit;
        end
      end
      StInit: begin
        cmd_o.walk_init = 1'b1;
        if (sts_i.is_clear || !sts_i.walk_any) state_d = StOut;
        else state_d = StRdFirst;
      end
      StRdFirst: begin
        // oldest sample read, data arrives next cycle
        cmd_o.rd = 1'b1;
        state_d  = StCapFirst;
      end
      StCapFirst: begin
        cmd_o.cap_cur = 1'b1;
        cmd_o.rd      = 1'b1;
        state_d       = StCapPair;
      end
      StCapPair: begin
        cmd_o.cap_nxt = 1'b1;
        state_d       = StStart;
      end
      StStart: begin
        if (sts_i.pair_skip) begin
          if (sts_i.walk_last) state_d = StAvg;
          else begin
            cmd_o.rd = 1'b1;
            state_d  = StCapPair;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StWait;
        end
      end
      StWait: begin
        if (sts_i.div_done) begin
          cmd_o.acc = 1'b1;
          if (sts_i.walk_last) state_d = StAvg;
          else begin
            cmd_o.rd = 1'b1;
            state_d  = StCapPair;
          end
        end
      end
      StAvg: begin
        if (!sts_i.any_pairs) state_d = StOut;
        else begin
          cmd_o.avg_start = 1'b1;
          state_d         = StAvgWait;
        end
      end
      StAvgWait: begin
        if (sts_i.div_done) state_d = StOut;
      end
      StOut: begin
        if (!out_full_i || out_taken_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule

// ===== rtl/awvt_dp.sv =====
// Datapath of the tracker: sample rings, min/max, pair velocity, divider, sums.
// Depends on awvt_pkg, awvt_ram, awvt_div.
module awvt_dp import awvt_pkg::*; #(
  parameter int unsigned Depth = DepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     action_i,
  input  logic signed [AngleW-1:0] angle_i,
  input  logic [TimeW-1:0]         time_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  output logic [VelW-1:0]          peak_o,
  output logic [VelW-1:0]          avg_o,
  output logic signed [AngleW-1:0] min_o,
  output logic signed [AngleW-1:0] max_o,
  output logic                     full_o,
  output logic [FillW-1:0]         fill_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0] wslot_q, wslot_d;
  logic [CW-1:0] valid_q, valid_d;
  logic signed [AngleW-1:0] min_q, max_q, min_d, max_d;
  logic clr_q;
  logic [AW-1:0] ptr_q;
  logic [CW-1:0] left_q; // pairs not yet captured
  logic signed [AngleW-1:0] a0_q;
  logic [TimeW-1:0] t0_q;
  logic signed [AngleW:0] d_q;
  logic [TimeW-1:0] dt_q;
  logic [VelW-1:0] peak_q;
  logic [SumW-1:0] sum_q;
  logic [CW-1:0] pairs_q;
  logic [SW-1:0] start_sum;
  logic [AW-1:0] start_slot;
  logic [NumW-1:0] mag_num;
  logic signed [AngleW:0] d_w;
  logic [AngleW-1:0] mag;
  logic [TimeW-1:0] dt_w;
  logic [AW-1:0] addr;
  logic we;
  logic signed [AngleW-1:0] a_rd;
  logic [TimeW-1:0] t_rd;
  logic div_start, div_done;
  logic [SumW-1:0] div_num, quo;
  logic [TimeW-1:0] div_den;
  logic [VelW-1:0] v;

  // Ring write at take, reads follow the walk pointer otherwise
  assign we   = cmd_i.take && !action_i;
  assign addr = cmd_i.take ? wslot_q : ptr_q;

  awvt_ram #(.Width(AngleW), .Depth(1 << AW)) u_angle_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(angle_i), .rdata_o(a_rd)
  );
  awvt_ram #(.Width(TimeW), .Depth(1 << AW)) u_time_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(time_i), .rdata_o(t_rd)
  );

  // Window and min/max update
  always_comb begin
    wslot_d = wslot_q;
    valid_d = valid_q;
    min_d   = min_q;
    max_d   = max_q;
    if (cmd_i.take) begin
      if (action_i) begin
        wslot_d = '0;
        valid_d = '0;
        min_d   = MinReset;
        max_d   = MaxReset;
      end else begin
        wslot_d = (wslot_q == AW'(Depth - 1)) ? '0 : AW'(wslot_q + 1'b1);
        if (valid_q != CW'(Depth)) valid_d = valid_q + 1'b1;
        if (angle_i < min_q) min_d = angle_i;
        if (angle_i > max_q) max_d = angle_i;
      end
    end
  end

  // Oldest slot: write slot minus fill, wrapped once
  assign start_sum  = SW'(wslot_q) + SW'(Depth) - SW'(valid_q);
  assign start_slot = (start_sum >= SW'(Depth)) ? AW'(start_sum - SW'(Depth)) : AW'(start_sum);

  // Pair difference: earlier minus later, time step later minus earlier
  assign d_w     = {a0_q[AngleW-1], a0_q} - {a_rd[AngleW-1], a_rd};
  assign dt_w    = t_rd - t0_q;
  assign mag     = d_q[AngleW] ? AngleW'(-d_q) : AngleW'(d_q);
  assign mag_num = NumW'(mag) * NumW'(MsPerS);

  assign div_start = cmd_i.div_start || cmd_i.avg_start;
  assign div_num   = cmd_i.avg_start ? sum_q : SumW'(mag_num);
  assign div_den   = cmd_i.avg_start ? TimeW'(pairs_q) : dt_q;
  assign v         = VelW'(quo);

  awvt_div #(.NW(SumW), .DW(TimeW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q <= '0;
      valid_q <= '0;
      min_q   <= MinReset;
      max_q   <= MaxReset;
      clr_q   <= 1'b0;
      left_q  <= '0;
      pairs_q <= '0;
    end else begin
      wslot_q <= wslot_d;
      valid_q <= valid_d;
      min_q   <= min_d;
      max_q   <= max_d;
      if (cmd_i.take) clr_q <= action_i;
      if (cmd_i.walk_init) begin
        left_q  <= valid_q - 1'b1;
        pairs_q <= '0;
      end else begin
        if (cmd_i.cap_nxt) left_q <= left_q - 1'b1;
        if (cmd_i.acc) pairs_q <= pairs_q + 1'b1;
      end
    end
  end

  // Walk pointer, captures and accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      ptr_q <= start_slot;
    end else if (cmd_i.rd) begin
      ptr_q <= (ptr_q == AW'(Depth - 1)) ? '0 : AW'(ptr_q + 1'b1);
    end
    // later sample of a pair becomes the earlier one of the next
    if (cmd_i.cap_cur || cmd_i.cap_nxt) begin
      a0_q <= a_rd;
      t0_q <= t_rd;
    end
    if (cmd_i.cap_nxt) begin
      d_q  <= d_w;
      dt_q <= dt_w;
    end
    if (cmd_i.walk_init) begin
      peak_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= sum_q + SumW'(v);
      if (!d_q[AngleW] && d_q != '0 && v > peak_q) peak_q <= v;
    end
  end

  assign sts_o.is_clear  = clr_q;
  assign sts_o.walk_any  = valid_q >= CW'(2);
  assign sts_o.walk_last = (left_q == '0);
  assign sts_o.pair_skip = (dt_q == '0);
  assign sts_o.div_done  = div_done;
  assign sts_o.any_pairs = (pairs_q != '0);

  assign peak_o = peak_q;
  assign avg_o  = (pairs_q == '0) ? '0 : v;
  assign min_o  = min_q;
  assign max_o  = max_q;
  assign full_o = (valid_q == CW'(Depth));
  assign fill_o = FillW'(valid_q);
endmodule
